// File: rtl/core/tpcrt_pkg.sv
// Shared types and constants for the two-prime CRT limb recomposer.
// Used by tpcrt_mulmod, tpcrt_dpath, tpcrt_ctrl and two_prime_crt_limb_recompose.
// No dependencies.
package tpcrt_pkg;

   localparam int MAX_LIMBS = 4096;
   localparam int RES_W     = 52;   // signed residue field
   localparam int PRIME_W   = 51;
   localparam int V_W       = 102;  // Garner value p1*t + r1
   localparam int ACC_W     = 256;  // window accumulator
   localparam int LIMB_W    = 64;
   localparam int NLI_W     = 13;   // limb index
   localparam int LOW_W     = 12;
   localparam int BITS_W    = 6;
   localparam int CNT_W     = 15;   // chunk counter
   localparam int POS_W     = 21;   // chunk bit position
   localparam int STEPS     = 52;   // multiplier bits per modular operation
   localparam int STEP_W    = 6;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [PRIME_W-1:0] PRIME_MIN = PRIME_W'(3);
   localparam logic [BITS_W-1:0] BITS_MIN = BITS_W'(40);
   localparam logic [BITS_W-1:0] BITS_MAX = BITS_W'(45);
   localparam logic [NLI_W-1:0] HIGH_MAX = NLI_W'(MAX_LIMBS);
   localparam logic [6:0] STRADDLE_SPAN = 7'd100;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_PRIME_FIRST  = 3'd0,
      CSR_PRIME_SECOND = 3'd1,
      CSR_GARNER_INV   = 3'd2,
      CSR_SCALE_FIRST  = 3'd3,
      CSR_SCALE_SECOND = 3'd4,
      CSR_CHUNK_BITS   = 3'd5,
      CSR_WIN_LOW      = 3'd6,
      CSR_WIN_HIGH     = 3'd7
   } csr_index_type;

   // effective (clamped) configuration
   typedef struct packed {
      logic [PRIME_W-1:0] prime_first;
      logic [PRIME_W-1:0] prime_second;
      logic [PRIME_W-1:0] garner_inverse;
      logic [PRIME_W-1:0] scale_first;
      logic [PRIME_W-1:0] scale_second;
      logic [BITS_W-1:0]  chunk_bits;
      logic [LOW_W-1:0]   window_low;
      logic [NLI_W-1:0]   window_high;
   } cfg_type;

   // modular operations run one after another per chunk
   typedef enum logic [3:0] {
      OP_RED_X1, OP_RED_S1, OP_MUL_1,
      OP_RED_X2, OP_RED_S2, OP_MUL_2,
      OP_RED_R1, OP_RED_INV, OP_MUL_T, OP_MUL_V
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_START, ST_WAIT, ST_DECIDE, ST_EMIT, ST_SHIFT, ST_ADD, ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      PL_NONE, PL_STRADDLE, PL_PLACE
   } place_type;

   typedef struct packed {
      logic   accept;       // latch chunk, advance counter
      logic   op_start;
      op_type op;
      logic   emit_place;   // emit limb 0 and jump to chunk's limb
      logic   make_addend;
      logic   do_add;
      logic   emit_flush;
      logic   flush_final;  // fourth flush limb carries last flag
   } cmd_type;

   typedef struct packed {
      logic      op_done;
      place_type kind;
      logic      gap;
      logic      flush_more;
      logic      out_free;
   } stat_type;

endpackage

// File: rtl/core/tpcrt_mulmod.sv
// Bit-serial multiply unit: a*b mod p, or a plain a*b when reduction is off.
// Depends on tpcrt_pkg.
module tpcrt_mulmod (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           reduce_en,
   input  logic [tpcrt_pkg::PRIME_W-1:0]  a,
   input  logic [tpcrt_pkg::RES_W-1:0]    b,
   input  logic [tpcrt_pkg::PRIME_W-1:0]  p,
   output logic [tpcrt_pkg::V_W-1:0]      result,
   output logic                           done
);
   logic [tpcrt_pkg::V_W-1:0]     acc_ff, acc_in;
   logic [tpcrt_pkg::PRIME_W-1:0] a_ff, p_ff;
   logic [tpcrt_pkg::RES_W-1:0]   b_ff;
   logic                          red_ff;
   logic [tpcrt_pkg::STEP_W-1:0]  step_ff;
   logic                          busy_ff, done_ff;
   logic [tpcrt_pkg::V_W-1:0]     dbl, dbl_r, sum, p_ext;

   // one multiplier bit per cycle, MSB first
   always_comb begin
      p_ext = tpcrt_pkg::V_W'(p_ff);
      dbl   = {acc_ff[tpcrt_pkg::V_W-2:0], 1'b0};
      dbl_r = (red_ff && dbl >= p_ext) ? dbl - p_ext : dbl;
      sum   = dbl_r + (b_ff[tpcrt_pkg::RES_W-1] ? tpcrt_pkg::V_W'(a_ff) : '0);
      acc_in = (red_ff && sum >= p_ext) ? sum - p_ext : sum;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == tpcrt_pkg::STEP_W'(tpcrt_pkg::STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // operands and accumulator
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         a_ff   <= a;
         b_ff   <= b;
         p_ff   <= p;
         red_ff <= reduce_en;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         b_ff   <= {b_ff[tpcrt_pkg::RES_W-2:0], 1'b0};
      end
   end

   assign result = acc_ff;
   assign done   = done_ff;
endmodule

// File: rtl/core/tpcrt_dpath.sv
// Datapath: residue registers, Garner arithmetic, window accumulator, limb output register.
// Depends on tpcrt_pkg and tpcrt_mulmod.
module tpcrt_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  tpcrt_pkg::cfg_type              cfg,
   input  tpcrt_pkg::cmd_type              cmd,
   output tpcrt_pkg::stat_type             stat,
   input  logic [2*tpcrt_pkg::RES_W-1:0]   req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tpcrt_pkg::LIMB_W-1:0]    rsp_tdata,
   output logic                            rsp_tlast
);
   localparam int PW = tpcrt_pkg::PRIME_W;
   localparam int RW = tpcrt_pkg::RES_W;

   logic [RW-1:0]                   res1_ff, res2_ff;
   logic [PW-1:0]                   tmp_ff, sc_ff, r1_ff, r2_ff, d_ff;
   logic [tpcrt_pkg::V_W-1:0]       v_ff;
   logic [tpcrt_pkg::ACC_W-1:0]     acc_ff, addend_ff;
   logic [tpcrt_pkg::CNT_W-1:0]     cnt_ff;
   logic [tpcrt_pkg::POS_W-1:0]     pos_ff;
   logic [tpcrt_pkg::NLI_W-1:0]     nli_ff;
   logic                            out_valid_ff, out_last_ff;
   logic [tpcrt_pkg::LIMB_W-1:0]    out_limb_ff;

   logic                            mm_red, mm_done;
   logic [PW-1:0]                   mm_a, mm_p, red_r, fix1, fix2;
   logic [RW-1:0]                   mm_b, mag1, mag2;
   logic [tpcrt_pkg::V_W-1:0]       mm_res;
   logic [PW+1:0]                   d_sum;
   logic [tpcrt_pkg::POS_W-1:0]     lo_pos, hi_pos;
   logic [tpcrt_pkg::CNT_W-1:0]     w, gap_w;
   logic [2:0]                      skip;
   logic [6:0]                      sh2;
   logic                            out_free, emit_last;

   // magnitudes of the signed residues
   assign mag1 = res1_ff[RW-1] ? (~res1_ff + 1'b1) : res1_ff;
   assign mag2 = res2_ff[RW-1] ? (~res2_ff + 1'b1) : res2_ff;

   // operand selection per operation
   always_comb begin
      mm_a   = PW'(1);
      mm_b   = '0;
      mm_p   = cfg.prime_first;
      mm_red = 1'b1;
      unique case (cmd.op)
         tpcrt_pkg::OP_RED_X1:  mm_b = mag1;
         tpcrt_pkg::OP_RED_S1:  mm_b = RW'(cfg.scale_first);
         tpcrt_pkg::OP_MUL_1: begin
            mm_a = tmp_ff;
            mm_b = RW'(sc_ff);
         end
         tpcrt_pkg::OP_RED_X2: begin
            mm_b = mag2;
            mm_p = cfg.prime_second;
         end
         tpcrt_pkg::OP_RED_S2: begin
            mm_b = RW'(cfg.scale_second);
            mm_p = cfg.prime_second;
         end
         tpcrt_pkg::OP_MUL_2: begin
            mm_a = tmp_ff;
            mm_b = RW'(sc_ff);
            mm_p = cfg.prime_second;
         end
         tpcrt_pkg::OP_RED_R1: begin
            mm_b = RW'(r1_ff);
            mm_p = cfg.prime_second;
         end
         tpcrt_pkg::OP_RED_INV: begin
            mm_b = RW'(cfg.garner_inverse);
            mm_p = cfg.prime_second;
         end
         tpcrt_pkg::OP_MUL_T: begin
            mm_a = d_ff;
            mm_b = RW'(sc_ff);
            mm_p = cfg.prime_second;
         end
         tpcrt_pkg::OP_MUL_V: begin
            mm_a   = cfg.prime_first;
            mm_b   = RW'(tmp_ff);
            mm_red = 1'b0;
         end
         default: ;
      endcase
   end

   tpcrt_mulmod u_mulmod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.op_start),
      .reduce_en (mm_red),
      .a         (mm_a),
      .b         (mm_b),
      .p         (mm_p),
      .result    (mm_res),
      .done      (mm_done)
   );

   // result post-processing: sign fix and Garner difference
   assign red_r = mm_res[PW-1:0];
   assign fix1  = (res1_ff[RW-1] && red_r != '0) ? cfg.prime_first - red_r
                : (res1_ff[RW-1] ? '0 : red_r);
   assign fix2  = (res2_ff[RW-1] && red_r != '0) ? cfg.prime_second - red_r
                : (res2_ff[RW-1] ? '0 : red_r);
   assign d_sum = (PW+2)'(r2_ff) + (PW+2)'(cfg.prime_second) - (PW+2)'(red_r);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         res1_ff <= req_tdata[RW-1:0];
         res2_ff <= req_tdata[2*RW-1:RW];
      end
      if (mm_done) begin
         case (cmd.op) inside
            tpcrt_pkg::OP_RED_X1:  tmp_ff <= fix1;
            tpcrt_pkg::OP_RED_X2:  tmp_ff <= fix2;
            tpcrt_pkg::OP_RED_S1,
            tpcrt_pkg::OP_RED_S2,
            tpcrt_pkg::OP_RED_INV: sc_ff <= red_r;
            tpcrt_pkg::OP_MUL_1:   r1_ff <= red_r;
            tpcrt_pkg::OP_MUL_2:   r2_ff <= red_r;
            tpcrt_pkg::OP_RED_R1:
               d_ff <= (d_sum >= (PW+2)'(cfg.prime_second))
                     ? PW'(d_sum - (PW+2)'(cfg.prime_second)) : PW'(d_sum);
            tpcrt_pkg::OP_MUL_T:   tmp_ff <= red_r;
            tpcrt_pkg::OP_MUL_V:   v_ff <= mm_res + tpcrt_pkg::V_W'(r1_ff);
            default: ;
         endcase
      end
   end

   // placement classification
   assign lo_pos = tpcrt_pkg::POS_W'({cfg.window_low, 6'b0});
   assign hi_pos = tpcrt_pkg::POS_W'({cfg.window_high, 6'b0});
   assign w      = pos_ff[tpcrt_pkg::POS_W-1:6];
   assign gap_w  = w - tpcrt_pkg::CNT_W'(nli_ff);
   assign skip   = (gap_w >= tpcrt_pkg::CNT_W'(4)) ? 3'd4 : gap_w[2:0];
   assign sh2    = 7'(lo_pos - pos_ff);

   always_comb begin
      stat.kind = tpcrt_pkg::PL_NONE;
      if (cfg.window_high > tpcrt_pkg::NLI_W'(cfg.window_low) && pos_ff <= hi_pos) begin
         if (pos_ff < lo_pos) begin
            if (pos_ff + tpcrt_pkg::POS_W'(tpcrt_pkg::STRADDLE_SPAN) > lo_pos)
               stat.kind = tpcrt_pkg::PL_STRADDLE;
         end else if (w >= tpcrt_pkg::CNT_W'(nli_ff)) begin
            stat.kind = tpcrt_pkg::PL_PLACE;
         end
      end
   end

   assign out_free        = !out_valid_ff || rsp_tready;
   assign stat.op_done    = mm_done;
   assign stat.gap        = w > tpcrt_pkg::CNT_W'(nli_ff);
   assign stat.flush_more = nli_ff < cfg.window_high;
   assign stat.out_free   = out_free;
   assign emit_last       = (nli_ff + 1'b1 == cfg.window_high) || cmd.flush_final;

   // chunk position, limb index and accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         nli_ff <= '0;
         acc_ff <= '0;
      end else begin
         if (cmd.accept) begin
            if (cnt_ff != tpcrt_pkg::CNT_MAX) cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == '0) nli_ff <= tpcrt_pkg::NLI_W'(cfg.window_low);
         end
         if (cmd.emit_place) begin
            acc_ff <= acc_ff >> {skip, 6'b0};
            nli_ff <= tpcrt_pkg::NLI_W'(w);
         end
         if (cmd.emit_flush) begin
            acc_ff <= acc_ff >> tpcrt_pkg::LIMB_W;
            nli_ff <= nli_ff + 1'b1;
         end
         if (cmd.do_add) acc_ff <= acc_ff + addend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept)
         pos_ff <= tpcrt_pkg::POS_W'(cnt_ff) * tpcrt_pkg::POS_W'(cfg.chunk_bits);
      if (cmd.make_addend) begin
         if (stat.kind == tpcrt_pkg::PL_STRADDLE)
            addend_ff <= tpcrt_pkg::ACC_W'(v_ff) >> sh2;
         else
            addend_ff <= tpcrt_pkg::ACC_W'(v_ff) << pos_ff[5:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_place || cmd.emit_flush) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_place || cmd.emit_flush) begin
         out_limb_ff <= acc_ff[tpcrt_pkg::LIMB_W-1:0];
         out_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_limb_ff;
   assign rsp_tlast  = out_last_ff;
endmodule

// File: rtl/core/tpcrt_ctrl.sv
// Controller: sequences the modular operations, placement and flush of one chunk.
// Depends on tpcrt_pkg.
module tpcrt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tlast,
   output logic                 req_tready,
   input  tpcrt_pkg::stat_type  stat,
   output tpcrt_pkg::cmd_type   cmd
);
   tpcrt_pkg::state_type state_ff, state_in;
   tpcrt_pkg::op_type    op_ff;
   logic [1:0]           fcnt_ff;
   logic                 last_ff, flushed_ff;
   logic                 flush_end;

   assign flush_end = (state_ff == tpcrt_pkg::ST_FLUSH) &&
                      (!stat.flush_more || (stat.out_free && fcnt_ff == 2'd3));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tpcrt_pkg::ST_IDLE:
            if (req_tvalid && !flushed_ff) state_in = tpcrt_pkg::ST_START;
         tpcrt_pkg::ST_START: state_in = tpcrt_pkg::ST_WAIT;
         tpcrt_pkg::ST_WAIT:
            if (stat.op_done)
               state_in = (op_ff == tpcrt_pkg::OP_MUL_V) ? tpcrt_pkg::ST_DECIDE
                                                         : tpcrt_pkg::ST_START;
         tpcrt_pkg::ST_DECIDE: begin
            unique case (stat.kind)
               tpcrt_pkg::PL_STRADDLE: state_in = tpcrt_pkg::ST_SHIFT;
               tpcrt_pkg::PL_PLACE:
                  state_in = stat.gap ? tpcrt_pkg::ST_EMIT : tpcrt_pkg::ST_SHIFT;
               default:
                  state_in = last_ff ? tpcrt_pkg::ST_FLUSH : tpcrt_pkg::ST_IDLE;
            endcase
         end
         tpcrt_pkg::ST_EMIT:
            if (stat.out_free) state_in = tpcrt_pkg::ST_SHIFT;
         tpcrt_pkg::ST_SHIFT: state_in = tpcrt_pkg::ST_ADD;
         tpcrt_pkg::ST_ADD:
            state_in = last_ff ? tpcrt_pkg::ST_FLUSH : tpcrt_pkg::ST_IDLE;
         tpcrt_pkg::ST_FLUSH:
            if (flush_end) state_in = tpcrt_pkg::ST_IDLE;
         default: state_in = tpcrt_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.op     = op_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         tpcrt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid && !flushed_ff;
         end
         tpcrt_pkg::ST_START: cmd.op_start    = 1'b1;
         tpcrt_pkg::ST_EMIT:  cmd.emit_place  = stat.out_free;
         tpcrt_pkg::ST_SHIFT: cmd.make_addend = 1'b1;
         tpcrt_pkg::ST_ADD:   cmd.do_add      = 1'b1;
         tpcrt_pkg::ST_FLUSH: begin
            cmd.emit_flush  = stat.flush_more && stat.out_free;
            cmd.flush_final = fcnt_ff == 2'd3;
         end
         default: ;
      endcase
   end

   // state and sequencing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tpcrt_pkg::ST_IDLE;
         op_ff      <= tpcrt_pkg::OP_RED_X1;
         fcnt_ff    <= '0;
         last_ff    <= 1'b0;
         flushed_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.accept) begin
            op_ff   <= tpcrt_pkg::OP_RED_X1;
            fcnt_ff <= '0;
            last_ff <= req_tlast;
         end
         if (state_ff == tpcrt_pkg::ST_WAIT && stat.op_done &&
             op_ff != tpcrt_pkg::OP_MUL_V)
            op_ff <= tpcrt_pkg::op_type'(op_ff + 1'b1);
         if (cmd.emit_flush) fcnt_ff <= fcnt_ff + 1'b1;
         if (flush_end) flushed_ff <= 1'b1;
      end
   end
endmodule

// File: rtl/core/two_prime_crt_limb_recompose.sv
// Channel   Ports                                   Payload
// req       req_tvalid/req_tready/req_tdata/tlast   two signed residues, last chunk
// rsp       rsp_tvalid/rsp_tready/rsp_tdata/tlast   64-bit window limb, last limb
// csr       csr_valid/csr_ready/csr_index/csr_data  register writes, always ready
//
// One chunk is accepted, then passes through ten operations in the shared bit-serial
// modular multiplier, and then through placement.
// A closing chunk adds up to 4 limb transfers.
// Reset is synchronous and clears counters, accumulator and flags.
// A stalled rsp side holds the block only when a new limb must be emitted.
// Top level: configuration registers and clamping, controller, datapath, checks.
// Depends on tpcrt_pkg, tpcrt_ctrl, tpcrt_dpath.
module two_prime_crt_limb_recompose (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [2*tpcrt_pkg::RES_W-1:0]       req_tdata,  // residue_first, residue_second
   input  logic                                req_tlast,  // last_chunk
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tpcrt_pkg::LIMB_W-1:0]        rsp_tdata,  // limb
   output logic                                rsp_tlast,  // last_limb
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [2:0]                          csr_index,
   input  logic [tpcrt_pkg::PRIME_W-1:0]       csr_data
);
   logic [tpcrt_pkg::PRIME_W-1:0] p1_ff, p2_ff, inv_ff, s1_ff, s2_ff;
   logic [tpcrt_pkg::BITS_W-1:0]  bits_ff;
   logic [tpcrt_pkg::LOW_W-1:0]   low_ff;
   logic [tpcrt_pkg::NLI_W-1:0]   high_ff;
   tpcrt_pkg::cfg_type            cfg;
   tpcrt_pkg::cmd_type            cmd;
   tpcrt_pkg::stat_type           stat;

   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff   <= tpcrt_pkg::PRIME_MIN;
         p2_ff   <= tpcrt_pkg::PRIME_MIN;
         inv_ff  <= '0;
         s1_ff   <= tpcrt_pkg::PRIME_W'(1);
         s2_ff   <= tpcrt_pkg::PRIME_W'(1);
         bits_ff <= tpcrt_pkg::BITS_W'(42);
         low_ff  <= '0;
         high_ff <= tpcrt_pkg::HIGH_MAX;
      end else if (csr_valid) begin
         unique case (tpcrt_pkg::csr_index_type'(csr_index))
            tpcrt_pkg::CSR_PRIME_FIRST:  p1_ff   <= csr_data;
            tpcrt_pkg::CSR_PRIME_SECOND: p2_ff   <= csr_data;
            tpcrt_pkg::CSR_GARNER_INV:   inv_ff  <= csr_data;
            tpcrt_pkg::CSR_SCALE_FIRST:  s1_ff   <= csr_data;
            tpcrt_pkg::CSR_SCALE_SECOND: s2_ff   <= csr_data;
            tpcrt_pkg::CSR_CHUNK_BITS:   bits_ff <= csr_data[tpcrt_pkg::BITS_W-1:0];
            tpcrt_pkg::CSR_WIN_LOW:      low_ff  <= csr_data[tpcrt_pkg::LOW_W-1:0];
            tpcrt_pkg::CSR_WIN_HIGH:     high_ff <= csr_data[tpcrt_pkg::NLI_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp to usable values
   always_comb begin
      cfg.prime_first    = (p1_ff < tpcrt_pkg::PRIME_MIN) ? tpcrt_pkg::PRIME_MIN : p1_ff;
      cfg.prime_second   = (p2_ff < tpcrt_pkg::PRIME_MIN) ? tpcrt_pkg::PRIME_MIN : p2_ff;
      cfg.garner_inverse = inv_ff;
      cfg.scale_first    = s1_ff;
      cfg.scale_second   = s2_ff;
      cfg.chunk_bits     = (bits_ff < tpcrt_pkg::BITS_MIN) ? tpcrt_pkg::BITS_MIN
                         : ((bits_ff > tpcrt_pkg::BITS_MAX) ? tpcrt_pkg::BITS_MAX : bits_ff);
      cfg.window_low     = low_ff;
      cfg.window_high    = (high_ff > tpcrt_pkg::HIGH_MAX) ? tpcrt_pkg::HIGH_MAX : high_ff;
   end

   tpcrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tpcrt_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // a limb is only loaded into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_place || cmd.emit_flush) |-> stat.out_free)
      else $error("limb emitted into occupied output register");

   // the modular unit never finishes the cycle after it starts
   a_op_len: assert property (@(posedge clock) disable iff (reset)
      cmd.op_start |=> !stat.op_done)
      else $error("modular operation finished too early");

   // input is never ready when a modular operation finishes
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      stat.op_done |-> !req_tready)
      else $error("input ready during arithmetic");
endmodule
